@@ src/sfi_pkg.sv @@
package sfi_pkg;

  // Field widths of the words on the two channels and the configuration port.
  localparam int MILLER_W   = 5;
  localparam int AMP_W      = 16;
  localparam int INT_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int COUNT_W    = 3;

  // Atom coordinates and the phase word, both in units of 2^-16 turn.
  localparam int POS_W = 16;
  localparam int PH_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_POS0  = 3'd1;
  localparam int                   NUM_POS_REGS   = 4;

  // Quarter-wave polynomial: u = r/16384 held as x = r << 14 in Q28.
  localparam int R_W        = 14;
  localparam int X_W        = 29;
  localparam int Q_FRAC     = 28;
  localparam int TRIG_MAG_W = 13;
  localparam int TRIG_W     = 14;
  localparam logic [R_W:0] QUARTER = 15'd16384;

  localparam int HORNER_STEPS = 4;
  localparam logic [X_W-1:0] C9 = 29'd43068;
  // Horner constants in the order they are applied: C7, C5, C3, C1.
  localparam logic [X_W-1:0] HORNER_C [HORNER_STEPS] = '{
    29'd1256749, 29'd21392327, 29'd173399667, 29'd421657428
  };

  localparam logic [TRIG_MAG_W-1:0] TRIG_ONE = 13'd4096;
  localparam logic signed [TRIG_W-1:0] TRIG_MAX = 14'sd4096;
  localparam logic signed [TRIG_W-1:0] TRIG_MIN = -14'sd4096;

  // Quadrant codes, from the top two bits of the phase.
  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  // Pipeline plan: phase, sine/cosine evaluation, then sum/square/round.
  localparam int PH_STAGES = 1;
  localparam int SC_STAGES = HORNER_STEPS + 2;
  localparam int CB_STAGES = 3;
  localparam int NSTAGES   = PH_STAGES + SC_STAGES + CB_STAGES;

endpackage

@@ src/sfi_hkl_if.sv @@
interface sfi_hkl_if;
  import sfi_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MILLER_W-1:0] miller_h;
  logic signed [MILLER_W-1:0] miller_k;
  logic signed [MILLER_W-1:0] miller_l;

  modport source (output valid, output miller_h, output miller_k, output miller_l,
                  input ready);
  modport sink (input valid, input miller_h, input miller_k, input miller_l,
                output ready);
endinterface

@@ src/sfi_result_if.sv @@
interface sfi_result_if;
  import sfi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [AMP_W-1:0] amplitude_real;
  logic signed [AMP_W-1:0] amplitude_imag;
  logic [INT_W-1:0]        intensity;

  modport source (output valid, output amplitude_real, output amplitude_imag,
                  output intensity, input ready);
  modport sink (input valid, input amplitude_real, input amplitude_imag,
                input intensity, output ready);
endinterface

@@ src/sfi_phase.sv @@
module sfi_phase #(
  parameter int MAX_ATOMS  = 4,
  parameter int PHASE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [sfi_pkg::MILLER_W-1:0]  miller_h_i,
  input  logic signed [sfi_pkg::MILLER_W-1:0]  miller_k_i,
  input  logic signed [sfi_pkg::MILLER_W-1:0]  miller_l_i,
  input  logic [sfi_pkg::CFG_DATA_W-1:0]       atom_pos_i [MAX_ATOMS],
  output logic [sfi_pkg::PH_W-1:0]             phase_o    [MAX_ATOMS]
);
  import sfi_pkg::*;

  // Low phase bits dropped when the phase is held to fewer than 16 bits.
  localparam int QB = (PHASE_BITS < PH_W) ? (PH_W - PHASE_BITS) : 0;
  localparam logic [PH_W-1:0] PHASE_MASK = PH_W'({PH_W{1'b1}} << QB);

  logic [PH_W-1:0] he, ke, le;
  logic [PH_W-1:0] phase_d [MAX_ATOMS];
  logic [PH_W-1:0] phase_q [MAX_ATOMS];

  // The sum wraps modulo one turn, so only the low 16 bits are formed.
  always_comb begin
    he = PH_W'(miller_h_i);
    ke = PH_W'(miller_k_i);
    le = PH_W'(miller_l_i);
    for (int j = 0; j < MAX_ATOMS; j++) begin
      phase_d[j] = (he * atom_pos_i[j][0 +: POS_W]
                  + ke * atom_pos_i[j][POS_W +: POS_W]
                  + le * atom_pos_i[j][2*POS_W +: POS_W]) & PHASE_MASK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < MAX_ATOMS; j++) begin
        phase_q[j] <= phase_d[j];
      end
    end
  end

  assign phase_o = phase_q;

endmodule

@@ src/sfi_sincos.sv @@
module sfi_sincos (
  input  logic                                clk_i,
  input  logic [sfi_pkg::SC_STAGES-1:0]       en_i,
  input  logic [sfi_pkg::PH_W-1:0]            phase_i,
  output logic signed [sfi_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [sfi_pkg::TRIG_W-1:0]   sin_o
);
  import sfi_pkg::*;

  localparam int NH = HORNER_STEPS;

  // x^2 in Q28 with x = r << 14.
  function automatic logic [X_W-1:0] sq_q28(input logic [R_W:0] r);
    logic [X_W-1:0]   x;
    logic [2*X_W-1:0] p;
    x = {r, {R_W{1'b0}}};
    p = (2*X_W)'(x) * (2*X_W)'(x);
    return p[Q_FRAC +: X_W];
  endfunction

  // One Horner step: c - x2 * t in Q28, truncating.
  function automatic logic [X_W-1:0] horner(input logic [X_W-1:0] c,
                                            input logic [X_W-1:0] x2,
                                            input logic [X_W-1:0] t);
    logic [2*X_W-1:0] p;
    p = (2*X_W)'(x2) * (2*X_W)'(t);
    return c - p[Q_FRAC +: X_W];
  endfunction

  // Final x * t, rounded half up from Q28 to Q12 and capped at one.
  function automatic logic [TRIG_MAG_W-1:0] trig_q12(input logic [R_W:0] r,
                                                    input logic [X_W-1:0] t);
    logic [X_W-1:0]        x;
    logic [2*X_W-1:0]      p;
    logic [X_W-1:0]        rnd;
    logic [TRIG_MAG_W-1:0] q;
    x   = {r, {R_W{1'b0}}};
    p   = (2*X_W)'(x) * (2*X_W)'(t);
    rnd = p[Q_FRAC +: X_W] + X_W'(32768);
    q   = rnd[16 +: TRIG_MAG_W];
    return (q > TRIG_ONE) ? TRIG_ONE : q;
  endfunction

  logic [R_W:0]     ra_d, rb_d;
  logic [X_W-1:0]   x2a_q [NH];
  logic [X_W-1:0]   x2b_q [NH];
  logic [R_W:0]     ra_q  [NH+1];
  logic [R_W:0]     rb_q  [NH+1];
  logic [1:0]       quad_q [NH+1];
  logic [X_W-1:0]   ta_q  [NH];
  logic [X_W-1:0]   tb_q  [NH];
  logic [X_W-1:0]   ta_in [NH];
  logic [X_W-1:0]   tb_in [NH];
  logic [TRIG_MAG_W-1:0] a_mag, b_mag;
  logic signed [TRIG_W-1:0] a_s, b_s;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  // The sine polynomial is used at r and at the complementary angle for cosine.
  always_comb begin
    ra_d = {1'b0, phase_i[R_W-1:0]};
    rb_d = QUARTER - ra_d;
    ta_in[0] = C9;
    tb_in[0] = C9;
    for (int k = 1; k < NH; k++) begin
      ta_in[k] = ta_q[k-1];
      tb_in[k] = tb_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x2a_q[0]  <= sq_q28(ra_d);
      x2b_q[0]  <= sq_q28(rb_d);
      ra_q[0]   <= ra_d;
      rb_q[0]   <= rb_d;
      quad_q[0] <= phase_i[PH_W-1 -: 2];
    end
    for (int k = 0; k < NH; k++) begin
      if (en_i[k+1]) begin
        ta_q[k]     <= horner(HORNER_C[k], x2a_q[k], ta_in[k]);
        tb_q[k]     <= horner(HORNER_C[k], x2b_q[k], tb_in[k]);
        ra_q[k+1]   <= ra_q[k];
        rb_q[k+1]   <= rb_q[k];
        quad_q[k+1] <= quad_q[k];
        if (k + 1 < NH) begin
          x2a_q[k+1] <= x2a_q[k];
          x2b_q[k+1] <= x2b_q[k];
        end
      end
    end
  end

  always_comb begin
    a_mag = trig_q12(ra_q[NH], ta_q[NH-1]);
    b_mag = trig_q12(rb_q[NH], tb_q[NH-1]);
    a_s   = signed'({1'b0, a_mag});
    b_s   = signed'({1'b0, b_mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NH+1]) begin
      case (quad_q[NH])
        QUAD_I: begin
          cos_q <= b_s;
          sin_q <= a_s;
        end
        QUAD_II: begin
          cos_q <= -a_s;
          sin_q <= b_s;
        end
        QUAD_III: begin
          cos_q <= -b_s;
          sin_q <= -a_s;
        end
        default: begin
          cos_q <= a_s;
          sin_q <= -b_s;
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

@@ src/sfi_combine.sv @@
module sfi_combine #(
  parameter int MAX_ATOMS = 4
) (
  input  logic                               clk_i,
  input  logic [sfi_pkg::CB_STAGES-1:0]      en_i,
  input  logic [MAX_ATOMS-1:0]               lane_en_i,
  input  logic signed [sfi_pkg::TRIG_W-1:0]  cos_i [MAX_ATOMS],
  input  logic signed [sfi_pkg::TRIG_W-1:0]  sin_i [MAX_ATOMS],
  output logic signed [sfi_pkg::AMP_W-1:0]   amplitude_real_o,
  output logic signed [sfi_pkg::AMP_W-1:0]   amplitude_imag_o,
  output logic [sfi_pkg::INT_W-1:0]          intensity_o
);
  import sfi_pkg::*;

  // Sums reach +/- MAX_ATOMS * 4096.
  localparam int SUM_W = $clog2(MAX_ATOMS * 4096 + 1) + 1;
  localparam int SQ_W  = 2 * SUM_W;
  localparam int MAG_W = SQ_W + 1;
  localparam int INT_CAP = (1 << INT_W) - 1;

  function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [SUM_W-1:0] v);
    int w;
    w = int'(v);
    if (w > 32767) begin
      return 16'sh7FFF;
    end else if (w < -32768) begin
      return -16'sh8000;
    end
    return AMP_W'(w);
  endfunction

  logic signed [SUM_W-1:0] re_d, im_d;
  logic signed [SUM_W-1:0] re_q, im_q;
  logic signed [SQ_W-1:0]  sq_re_d, sq_im_d;
  logic [SQ_W-1:0]         sq_re_q, sq_im_q;
  logic signed [AMP_W-1:0] amp_re_q, amp_im_q;
  logic [MAG_W-1:0]        mag, mag_rnd;
  logic [INT_W-1:0]        int_d;
  logic signed [AMP_W-1:0] out_re_q, out_im_q;
  logic [INT_W-1:0]        out_int_q;

  // Only the atoms below the configured count take part.
  always_comb begin
    re_d = '0;
    im_d = '0;
    for (int j = 0; j < MAX_ATOMS; j++) begin
      if (lane_en_i[j]) begin
        re_d = re_d + SUM_W'(cos_i[j]);
        im_d = im_d + SUM_W'(sin_i[j]);
      end
    end
  end

  always_comb begin
    sq_re_d = re_q * re_q;
    sq_im_d = im_q * im_q;
  end

  // The squared magnitude is formed in Q24 from the unsaturated sums.
  always_comb begin
    mag     = MAG_W'(sq_re_q) + MAG_W'(sq_im_q);
    mag_rnd = (mag + MAG_W'(2048)) >> 12;
    if (mag_rnd > MAG_W'(INT_CAP)) begin
      int_d = INT_W'(INT_CAP);
    end else begin
      int_d = INT_W'(mag_rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      re_q <= re_d;
      im_q <= im_d;
    end
    if (en_i[1]) begin
      sq_re_q  <= unsigned'(sq_re_d);
      sq_im_q  <= unsigned'(sq_im_d);
      amp_re_q <= sat_amp(re_q);
      amp_im_q <= sat_amp(im_q);
    end
    if (en_i[2]) begin
      out_re_q  <= amp_re_q;
      out_im_q  <= amp_im_q;
      out_int_q <= int_d;
    end
  end

  assign amplitude_real_o = out_re_q;
  assign amplitude_imag_o = out_im_q;
  assign intensity_o      = out_int_q;

endmodule

@@ src/structure_factor_intensity.sv @@
// A word accepted at the input passes the phase, sine/cosine and combine stages in turn.
// Throughput: one word per cycle while the output is not stalled; every stage holds one
// word and moves on as soon as the stage after it is free, so a stalled output
// only stops the stages behind it.
// Reset (rst_ni low, asynchronous) empties the pipeline, sets atom_count to 1 and
// clears all atom positions to zero. There is no clearing pass after reset.
module structure_factor_intensity #(
  parameter int MAX_ATOMS  = 4,
  parameter int PHASE_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sfi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sfi_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  sfi_hkl_if.sink                            hkl_i,
  sfi_result_if.source                       result_o
);
  import sfi_pkg::*;

  // Stage that holds the finished sine and cosine of every atom.
  localparam int SC_LAST = PH_STAGES + SC_STAGES - 1;

  // Configuration registers. Position registers beyond the four on the port
  // stay at zero, as they can never be written.
  logic [COUNT_W-1:0]    atom_count_q;
  logic [CFG_DATA_W-1:0] atom_pos_q [MAX_ATOMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= COUNT_W'(1);
      for (int j = 0; j < MAX_ATOMS; j++) begin
        atom_pos_q[j] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_ATOM_COUNT) begin
        atom_count_q <= cfg_data_i[COUNT_W-1:0];
      end
      for (int j = 0; j < MAX_ATOMS; j++) begin
        if (j < NUM_POS_REGS &&
            cfg_index_i == CFG_IDX_W'(int'(REG_ATOM_POS0) + j)) begin
          atom_pos_q[j] <= cfg_data_i;
        end
      end
    end
  end

  // A lane takes part when its index is below the atom count; counts above
  // MAX_ATOMS simply enable every lane.
  logic [MAX_ATOMS-1:0] lane_en;

  always_comb begin
    for (int j = 0; j < MAX_ATOMS; j++) begin
      lane_en[j] = (j < int'(atom_count_q));
    end
  end

  // Pipeline control. Each stage carries a valid bit alongside its data and
  // loads when it is empty or when the stage after it is loading too. The last
  // stage is the output register, so a waiting result never blocks bubbles
  // further back from being filled.
  logic [NSTAGES-1:0] valid_q;
  logic [NSTAGES:0]   stage_en;

  always_comb begin
    stage_en[NSTAGES] = result_o.ready;
    for (int i = NSTAGES - 1; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= hkl_i.valid;
      end
      for (int i = 1; i < NSTAGES; i++) begin
        if (stage_en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign hkl_i.ready    = stage_en[0];
  assign result_o.valid = valid_q[NSTAGES-1];

  // Stage 0: wrapped phase of every atom.
  logic [PH_W-1:0] phase_w [MAX_ATOMS];

  sfi_phase #(
    .MAX_ATOMS  (MAX_ATOMS),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i      (clk_i),
    .en_i       (stage_en[0]),
    .miller_h_i (hkl_i.miller_h),
    .miller_k_i (hkl_i.miller_k),
    .miller_l_i (hkl_i.miller_l),
    .atom_pos_i (atom_pos_q),
    .phase_o    (phase_w)
  );

  // Stages 1 to 6: one sine/cosine evaluator per atom, each a Horner chain
  // with one multiply per stage for the sine and one for the cosine.
  logic signed [TRIG_W-1:0] cos_w [MAX_ATOMS];
  logic signed [TRIG_W-1:0] sin_w [MAX_ATOMS];

  for (genvar j = 0; j < MAX_ATOMS; j++) begin : g_lane
    sfi_sincos u_sincos (
      .clk_i   (clk_i),
      .en_i    (stage_en[PH_STAGES +: SC_STAGES]),
      .phase_i (phase_w[j]),
      .cos_o   (cos_w[j]),
      .sin_o   (sin_w[j])
    );
  end

  // Stages 7 to 9: sum over atoms, squares, then rounding into the output word.
  sfi_combine #(
    .MAX_ATOMS (MAX_ATOMS)
  ) u_combine (
    .clk_i            (clk_i),
    .en_i             (stage_en[PH_STAGES + SC_STAGES +: CB_STAGES]),
    .lane_en_i        (lane_en),
    .cos_i            (cos_w),
    .sin_i            (sin_w),
    .amplitude_real_o (result_o.amplitude_real),
    .amplitude_imag_o (result_o.amplitude_imag),
    .intensity_o      (result_o.intensity)
  );

  // An accepted word must occupy the first stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hkl_i.valid && hkl_i.ready |=> valid_q[0])
    else $error("accepted word missing from first stage");

  // With every stage full and the output stalled, no new word may enter.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && !result_o.ready |-> !hkl_i.ready)
    else $error("input ready while pipeline full and stalled");

  // The valid sine and cosine of atom 0 never exceed one in magnitude.
  a_trig_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[SC_LAST] |-> (cos_w[0] <= TRIG_MAX && cos_w[0] >= TRIG_MIN &&
                          sin_w[0] <= TRIG_MAX && sin_w[0] >= TRIG_MIN))
    else $error("sine or cosine out of range");

endmodule
